[rtl/tael_pkg.sv]
package tael_pkg;

	localparam int VAL_W = 32;
	localparam int TS_W = 32;
	localparam int CH_W = 3;
	localparam int AGE_W = 4;
	localparam int CNT_W = 5;
	localparam int CNT_EXT_W = 9;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_REARM = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_READ = 2'd3;

	typedef struct packed {
		logic [TS_W-1:0] ts;
		logic [CH_W-1:0] ch;
		logic [VAL_W-1:0] thr;
		logic [VAL_W-1:0] val;
	} log_entry_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

endpackage

[rtl/tael_ctrl.sv]
module tael_ctrl
	import tael_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output ctrl_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_RESP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == ST_IDLE) || ((state_q == ST_RESP) && out_ready);
	assign out_valid = (state_q == ST_RESP);
	assign cmd.load = in_valid && in_ready;
	assign cmd.exec = (state_q == ST_EXEC);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_ready) state_d = in_valid ? ST_EXEC : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/tael_datapath.sv]
module tael_datapath
	import tael_pkg::*;
#(
	parameter int CHANNELS = 8,
	parameter int LOG_DEPTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctrl_cmd_t               cmd,
	input  logic                    cfg_we,
	input  logic                    cfg_wdata,
	input  logic [1:0]              opcode,
	input  logic [CH_W-1:0]         channel,
	input  logic signed [VAL_W-1:0] sample_value,
	input  logic signed [VAL_W-1:0] threshold,
	input  logic [TS_W-1:0]         timestamp,
	input  logic                    last_of_scan,
	input  logic [AGE_W-1:0]        read_index,
	output logic                    fired,
	output logic                    report,
	output logic                    rec_valid,
	output logic [TS_W-1:0]         rec_timestamp,
	output logic [CH_W-1:0]         rec_channel,
	output logic signed [VAL_W-1:0] rec_threshold,
	output logic signed [VAL_W-1:0] rec_value,
	output logic [CNT_W-1:0]        log_count
);

	localparam int AW = $clog2(LOG_DEPTH);
	localparam int CW = $clog2(LOG_DEPTH + 1);
	localparam int SW = ((AW > AGE_W) ? AW : AGE_W) + 2;

	logic [1:0]          op_q;
	logic [CH_W-1:0]     ch_q;
	logic [VAL_W-1:0]    val_q;
	logic [VAL_W-1:0]    thr_q;
	logic [TS_W-1:0]     ts_q;
	logic                last_q;
	logic [AGE_W-1:0]    age_q;

	logic                report_en_q;
	logic [CHANNELS-1:0] flags_q;
	logic [CHANNELS-1:0] flags_d;
	logic                primed_q;
	logic [AW-1:0]       head_q;
	logic [CW-1:0]       entries_q;

	logic                fired_q;
	logic                report_q;
	logic                rec_valid_q;
	logic                from_mem_q;

	log_entry_t          mem [LOG_DEPTH];
	log_entry_t          rd_q;
	log_entry_t          wr_entry;

	logic                ch_ok;
	logic                flag_cur;
	logic                thr_zero;
	logic                over;
	logic                trig;
	logic                read_hit;
	logic signed [SW-1:0] diff;
	logic [AW-1:0]       slot;
	logic [CNT_EXT_W-1:0] entries_ext;

	assign ch_ok = (32'(ch_q) < CHANNELS);
	assign thr_zero = (thr_q == '0);
	assign over = ($signed(val_q) > $signed(thr_q));
	assign entries_ext = CNT_EXT_W'(entries_q);
	assign read_hit = (CNT_EXT_W'(age_q) < entries_ext);

	always_comb begin
		flag_cur = 1'b0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (32'(ch_q) == i) flag_cur = flags_q[i];
		end
	end

	assign trig = (op_q == OP_SAMPLE) && ch_ok && !thr_zero && primed_q && over && !flag_cur;

	always_comb begin
		flags_d = flags_q;
		for (int i = 0; i < CHANNELS; i++) begin
			if (32'(ch_q) == i) begin
				if (op_q == OP_SAMPLE) begin
					flags_d[i] = !thr_zero && over;
				end else if (op_q == OP_REARM) begin
					flags_d[i] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		diff = $signed(SW'(head_q)) - $signed(SW'(1)) - $signed(SW'(age_q));
		if (diff < 0) diff = diff + $signed(SW'(LOG_DEPTH));
		slot = diff[AW-1:0];
	end

	assign wr_entry.ts = ts_q;
	assign wr_entry.ch = ch_q;
	assign wr_entry.thr = thr_q;
	assign wr_entry.val = val_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
			ch_q <= channel;
			val_q <= sample_value;
			thr_q <= threshold;
			ts_q <= timestamp;
			last_q <= last_of_scan;
			age_q <= read_index;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && trig) mem[head_q] <= wr_entry;
		if (cmd.exec && (op_q == OP_READ)) rd_q <= mem[slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_en_q <= 1'b0;
		end else if (cfg_we) begin
			report_en_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			primed_q <= 1'b0;
			head_q <= '0;
			entries_q <= '0;
			fired_q <= 1'b0;
			report_q <= 1'b0;
			rec_valid_q <= 1'b0;
			from_mem_q <= 1'b0;
		end else if (cmd.exec) begin
			flags_q <= flags_d;
			if ((op_q == OP_SAMPLE) && last_q) primed_q <= 1'b1;
			if (op_q == OP_CLEAR) begin
				head_q <= '0;
				entries_q <= '0;
			end else if (trig) begin
				head_q <= (head_q == AW'(LOG_DEPTH - 1)) ? '0 : head_q + 1'b1;
				if (entries_q != CW'(LOG_DEPTH)) entries_q <= entries_q + 1'b1;
			end
			fired_q <= trig;
			report_q <= trig && report_en_q;
			rec_valid_q <= trig || ((op_q == OP_READ) && read_hit);
			from_mem_q <= (op_q == OP_READ);
		end
	end

	assign fired = fired_q;
	assign report = report_q;
	assign rec_valid = rec_valid_q;
	assign rec_timestamp = !rec_valid_q ? '0 : (from_mem_q ? rd_q.ts : ts_q);
	assign rec_channel = !rec_valid_q ? '0 : (from_mem_q ? rd_q.ch : ch_q);
	assign rec_threshold = !rec_valid_q ? '0 : (from_mem_q ? rd_q.thr : thr_q);
	assign rec_value = !rec_valid_q ? '0 : (from_mem_q ? rd_q.val : val_q);
	assign log_count = entries_ext[CNT_W-1:0];

endmodule

[rtl/threshold_alarm_edge_logger.sv]
// An accepted transaction is registered, the log memory is written or read in the
// execute state, and the registered result is offered in the response state. A new
// transaction is accepted only once the previous result has been taken.
// Reset: arst_n clears the over flags, priming, the log count and report_enable;
// the log memory itself is not cleared and needs no clearing pass.
module threshold_alarm_edge_logger
	import tael_pkg::*;
#(
	parameter int CHANNELS = 8,
	parameter int LOG_DEPTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              opcode,
	input  logic [CH_W-1:0]         channel,
	input  logic signed [VAL_W-1:0] sample_value,
	input  logic signed [VAL_W-1:0] threshold,
	input  logic [TS_W-1:0]         timestamp,
	input  logic                    last_of_scan,
	input  logic [AGE_W-1:0]        read_index,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    fired,
	output logic                    report,
	output logic                    rec_valid,
	output logic [TS_W-1:0]         rec_timestamp,
	output logic [CH_W-1:0]         rec_channel,
	output logic signed [VAL_W-1:0] rec_threshold,
	output logic signed [VAL_W-1:0] rec_value,
	output logic [CNT_W-1:0]        log_count
);

	ctrl_cmd_t cmd;

	tael_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	tael_datapath #(
		.CHANNELS  (CHANNELS),
		.LOG_DEPTH (LOG_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.opcode        (opcode),
		.channel       (channel),
		.sample_value  (sample_value),
		.threshold     (threshold),
		.timestamp     (timestamp),
		.last_of_scan  (last_of_scan),
		.read_index    (read_index),
		.fired         (fired),
		.report        (report),
		.rec_valid     (rec_valid),
		.rec_timestamp (rec_timestamp),
		.rec_channel   (rec_channel),
		.rec_threshold (rec_threshold),
		.rec_value     (rec_value),
		.log_count     (log_count)
	);

endmodule
